>>> hw/rtl/ustc_pkg.sv
// Package for the Unix time to UTC calendar converter.
// Holds the reciprocal constants, the pipeline depth and the calendar helper functions.
// No dependencies.
package ustc_pkg;

  // Number of register stages from input beat to result beat.
  localparam int NumStages = 7;

  // Seconds per day is 2^7 * 675: the low seven bits pass straight into the time of day.
  localparam int DayShift = 7;
  localparam logic [9:0]  DayDiv = 10'd675;
  // floor(2^34 / 675); the quotient estimate is exact or one low.
  localparam logic [24:0] DayRecip = 25'd25451658;
  localparam int DayRecipShift = 34;

  // floor(2^19 * 4 / 1461); the year estimate is exact or one low over the whole range.
  localparam logic [10:0] YearRecip = 11'd1435;
  localparam int YearRecipShift = 19;

  // floor(2^28 / 3600) and floor(2^18 / 60); both estimates are exact or one low.
  localparam logic [16:0] SecsPerHour = 17'd3600;
  localparam logic [16:0] HourRecip = 17'd74565;
  localparam int HourRecipShift = 28;
  localparam logic [11:0] SecsPerMin = 12'd60;
  localparam logic [12:0] MinRecip = 13'd4369;
  localparam int MinRecipShift = 18;

  localparam logic [11:0] EpochYear = 12'd1970;
  localparam logic [11:0] LastYear = 12'd2106;
  // Offset of the year 2100 from the epoch: the only non-leap century year inside the range.
  localparam logic [7:0] Century2100Off = 8'd130;

  // First day of year (1970 + k), counted in days from the epoch.
  function automatic logic [15:0] year_start(input logic [7:0] k);
    logic [16:0] acc;
    logic [8:0] k1;
    acc = 17'(k) * 17'd365;
    k1 = 9'(k) + 9'd1;
    acc = acc + 17'(k1 >> 2);
    if (k > Century2100Off) begin
      acc = acc - 17'd1;
    end
    return acc[15:0];
  endfunction

  // Leap years inside the range are the multiples of four, except 2100.
  function automatic logic is_leap(input logic [7:0] k);
    return (k[1:0] == 2'd2) && (k != Century2100Off);
  endfunction

  // Day of year on which month m (0 is January) starts.
  function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
    logic [8:0] base;
    unique case (m)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      default: base = 9'd0;
    endcase
    if (leap && (m >= 4'd2)) begin
      base = base + 9'd1;
    end
    return base;
  endfunction

endpackage

>>> hw/rtl/unix_seconds_to_utc_calendar.sv
// Top level of the Unix time to UTC calendar converter.
// Seven-stage pipeline built on the constants and functions of ustc_pkg.
//
// Converts an unsigned 32-bit count of seconds since 1970-01-01 00:00:00 UTC into the
// Gregorian year, month, day, hour, minute and second, one result beat per input beat.
// The block is a pipeline of seven register stages; a new beat can be accepted on every
// cycle while result_ready is high, so the sustained rate is one conversion per clock
// unless the output stalls. Each stage carries a valid bit; a stage takes new data when
// it is empty or when the stage after it moves, so ready follows result_ready back
// through the stages in the same cycle and a stall holds in place each item whose next
// stage is full. Divisions by constants are done with reciprocal multiplies followed by a
// single correction step, and the year comes from an estimate that is fixed up by one
// compare against the closed-form start day of the next year. Leap seconds are not modeled.
module unix_seconds_to_utc_calendar
  import ustc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        valid,
  output logic        ready,
  input  logic [31:0] unix_seconds,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [11:0] year,
  output logic [3:0]  month,
  output logic [4:0]  day,
  output logic [4:0]  hour,
  output logic [5:0]  minute,
  output logic [5:0]  second
);

  // Stage valid bits and per-stage load enables.
  logic [NumStages-1:0] vld;
  logic [NumStages-1:0] en;

  always_comb begin
    en[NumStages-1] = !vld[NumStages-1] || result_ready;
    for (int i = NumStages - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign ready = en[0];
  assign result_valid = vld[NumStages-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= valid;
      end
      for (int i = 1; i < NumStages; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // Stage 1: estimate the day number as (seconds >> 7) / 675 by a reciprocal multiply.
  logic [49:0] day_prod_next;
  logic [24:0] s1_x;
  logic [6:0]  s1_secs_lo;
  logic [15:0] s1_qest;

  assign day_prod_next = 50'(unix_seconds[31:DayShift]) * 50'(DayRecip);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_x       <= unix_seconds[31:DayShift];
      s1_secs_lo <= unix_seconds[DayShift-1:0];
      s1_qest    <= day_prod_next[DayRecipShift+15:DayRecipShift];
    end
  end

  // Stage 2: the estimate may be one low; one compare and subtract settles the day number
  // and the time of day.
  logic [25:0] day_rem;
  logic [15:0] day_no_next;
  logic [9:0]  tod_hi_next;
  logic [15:0] s2_day_no;
  logic [16:0] s2_tod;

  always_comb begin
    day_rem = 26'(s1_x) - 26'(s1_qest) * 26'(DayDiv);
    if (day_rem >= 26'(DayDiv)) begin
      day_no_next = s1_qest + 16'd1;
      tod_hi_next = 10'(day_rem - 26'(DayDiv));
    end else begin
      day_no_next = s1_qest;
      tod_hi_next = day_rem[9:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_day_no <= day_no_next;
      s2_tod    <= {tod_hi_next, s1_secs_lo};
    end
  end

  // Stage 3: estimate the year offset from the day number and the hour from the time of
  // day. Both estimates are exact or one low.
  logic [26:0] yr_prod_next;
  logic [33:0] hr_prod_next;
  logic [15:0] s3_day_no;
  logic [7:0]  s3_yest;
  logic [16:0] s3_tod;
  logic [4:0]  s3_hest;

  assign yr_prod_next = 27'(s2_day_no) * 27'(YearRecip);
  assign hr_prod_next = 34'(s2_tod) * 34'(HourRecip);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_day_no <= s2_day_no;
      s3_yest   <= yr_prod_next[YearRecipShift+7:YearRecipShift];
      s3_tod    <= s2_tod;
      s3_hest   <= hr_prod_next[HourRecipShift+4:HourRecipShift];
    end
  end

  // Stage 4: correct the year offset against the first day of the following year, and
  // correct the hour against the remainder.
  logic [7:0]  yest_inc;
  logic [15:0] next_year_start;
  logic [7:0]  yoff_next;
  logic [16:0] hr_rem;
  logic [4:0]  hour_next;
  logic [11:0] hrem_next;
  logic [15:0] s4_day_no;
  logic [7:0]  s4_yoff;
  logic [4:0]  s4_hour;
  logic [11:0] s4_hrem;

  always_comb begin
    yest_inc = s3_yest + 8'd1;
    next_year_start = year_start(yest_inc);
    if (s3_day_no >= next_year_start) begin
      yoff_next = yest_inc;
    end else begin
      yoff_next = s3_yest;
    end
    hr_rem = s3_tod - 17'(s3_hest) * SecsPerHour;
    if (hr_rem >= SecsPerHour) begin
      hour_next = s3_hest + 5'd1;
      hrem_next = 12'(hr_rem - SecsPerHour);
    end else begin
      hour_next = s3_hest;
      hrem_next = hr_rem[11:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4_day_no <= s3_day_no;
      s4_yoff   <= yoff_next;
      s4_hour   <= hour_next;
      s4_hrem   <= hrem_next;
    end
  end

  // Stage 5: day of year, leap flag and calendar year; estimate the minute.
  logic [15:0] doy_wide;
  logic [24:0] min_prod_next;
  logic [8:0]  s5_doy;
  logic        s5_leap;
  logic [11:0] s5_year;
  logic [4:0]  s5_hour;
  logic [11:0] s5_hrem;
  logic [5:0]  s5_mest;

  assign doy_wide = s4_day_no - year_start(s4_yoff);
  assign min_prod_next = 25'(s4_hrem) * 25'(MinRecip);

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s5_doy  <= doy_wide[8:0];
      s5_leap <= is_leap(s4_yoff);
      s5_year <= EpochYear + 12'(s4_yoff);
      s5_hour <= s4_hour;
      s5_hrem <= s4_hrem;
      s5_mest <= min_prod_next[MinRecipShift+5:MinRecipShift];
    end
  end

  // Stage 6: pick the month by comparing the day of year against the start of every month after January in
  // parallel (the starts rise, so the last match wins); settle minute and second.
  logic [8:0]  mon_start;
  logic [3:0]  mi_next;
  logic [8:0]  mstart_next;
  logic [11:0] sec_rem;
  logic [5:0]  minute_next;
  logic [5:0]  second_next;
  logic [8:0]  s6_doy;
  logic [8:0]  s6_mstart;
  logic [3:0]  s6_mi;
  logic [11:0] s6_year;
  logic [4:0]  s6_hour;
  logic [5:0]  s6_minute;
  logic [5:0]  s6_second;

  always_comb begin
    mi_next = 4'd0;
    mstart_next = 9'd0;
    mon_start = 9'd0;
    for (int m = 1; m < 12; m++) begin
      mon_start = month_start(4'(m), s5_leap);
      if (s5_doy >= mon_start) begin
        mi_next = 4'(m);
        mstart_next = mon_start;
      end
    end
    sec_rem = s5_hrem - 12'(s5_mest) * SecsPerMin;
    if (sec_rem >= SecsPerMin) begin
      minute_next = s5_mest + 6'd1;
      second_next = 6'(sec_rem - SecsPerMin);
    end else begin
      minute_next = s5_mest;
      second_next = sec_rem[5:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s6_doy    <= s5_doy;
      s6_mstart <= mstart_next;
      s6_mi     <= mi_next;
      s6_year   <= s5_year;
      s6_hour   <= s5_hour;
      s6_minute <= minute_next;
      s6_second <= second_next;
    end
  end

  // Stage 7: day of month and the result register.
  logic [8:0] dom_wide;

  assign dom_wide = s6_doy - s6_mstart + 9'd1;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      year   <= s6_year;
      month  <= s6_mi + 4'd1;
      day    <= dom_wide[4:0];
      hour   <= s6_hour;
      minute <= s6_minute;
      second <= s6_second;
    end
  end

endmodule

>>> hw/rtl/ustc_checker.sv
// Port-level checker for the Unix time to UTC calendar converter.
// Uses ustc_pkg for the year range; bound to unix_seconds_to_utc_calendar below.
module ustc_checker
  import ustc_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        result_valid,
  input logic        result_ready,
  input logic [11:0] year,
  input logic [3:0]  month,
  input logic [4:0]  day,
  input logic [4:0]  hour,
  input logic [5:0]  minute,
  input logic [5:0]  second
);

  // A stalled result beat keeps its fields.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(year) && $stable(month)
      && $stable(day) && $stable(hour) && $stable(minute) && $stable(second))
    else $error("result beat changed while stalled");

  // Every delivered field lies in its calendar range; for the day only the lower bound is checked.
  a_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> year >= EpochYear && year <= LastYear && month >= 4'd1
      && month <= 4'd12 && day >= 5'd1 && hour <= 5'd23 && minute <= 6'd59
      && second <= 6'd59)
    else $error("result field out of range");

  // Short months never show a 31st, and February never passes its 29th.
  a_month_len: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(month == 4'd2 && day > 5'd29)
      && !(day == 5'd31 && (month == 4'd4 || month == 4'd6 || month == 4'd9
      || month == 4'd11)))
    else $error("day past the end of its month");

  // A February 29th only happens in a leap year of the covered range.
  a_leap_day: assert property (@(posedge clk) disable iff (rst)
    result_valid && month == 4'd2 && day == 5'd29 |-> year[1:0] == 2'd0
      && year != 12'd2100)
    else $error("leap day in a common year");

endmodule

bind unix_seconds_to_utc_calendar ustc_checker u_ustc_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .year         (year),
  .month        (month),
  .day          (day),
  .hour         (hour),
  .minute       (minute),
  .second       (second)
);
